// ===== rtl/xxh_pkg.sv =====
// XXH64 stream hash package: primes, the seed reset value, the rotate
// function and the multiplier step codes. No dependencies.
package xxh_pkg;

  localparam logic [63:0] PR1 = 64'h9E3779B185EBCA87;
  localparam logic [63:0] PR2 = 64'hC2B2AE3D27D4EB4F;
  localparam logic [63:0] PR3 = 64'h165667B19E3779F9;
  localparam logic [63:0] PR4 = 64'h85EBCA77C2B2AE63;
  localparam logic [63:0] PR5 = 64'h27D4EB2F165667C5;

  localparam logic [63:0] SEED_RESET = 64'h0;

  // Multiplier operation codes.
  typedef enum logic [1:0] {
    MUL_LO   = 2'd0,
    MUL_MID1 = 2'd1,
    MUL_MID2 = 2'd2
  } mul_step_t;

  function automatic logic [63:0] rotl(input logic [63:0] x, input logic [5:0] r);
    logic [127:0] d;
    d = {x, x} << r;
    return d[127:64];
  endfunction

endpackage

// ===== rtl/xxh64_stream_hash.sv =====
// XXH64 stream hash top level: sequencer, lane state and finalization.
// Depends on xxh_pkg and xxh_mul64.
//
// Computes XXH64 over a message of little-endian 64-bit words, last word
// carrying 0..8 bytes. Every 64-bit multiply goes through one shared
// iterative multiplier, which takes the operands on its start request, forms
// three partial products and then pulses done. A full word is buffered, or,
// when it completes a 32-byte stripe, runs the lane rounds (four lanes, two
// multiplies each). The last word adds finalization: it picks the start
// value, runs the lane merge for a message of 32 bytes or more, adds the
// length, folds in each pending word, a 4-byte group and each tail byte,
// then runs the avalanche and fills the output register. in_ready is low
// while a request is being worked on; a digest still waiting on out_ready
// only holds back the next digest. The lanes take the seed when a message
// starts; a message under 32 bytes uses the seed at finalization.
module xxh64_stream_hash (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_seed,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_data_word,
  input  logic [3:0]  in_byte_count,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_digest
);

  typedef enum logic [4:0] {
    S_IDLE, S_LR_A, S_LR_B, S_LR_C, S_LR_D, S_MG_SUM, S_MG_A, S_MG_B,
    S_MG_C, S_MG_D, S_MG_E, S_MG_F, S_LEN, S_PW_A, S_PW_B, S_PW_C, S_PW_D,
    S_PW_E, S_G4_A, S_G4_B, S_G4_C, S_B1_A, S_B1_B, S_AV_A, S_AV_B, S_AV_C,
    S_AV_D, S_OUT
  } state_t;

  state_t      state_r;
  logic [63:0] seed_r;
  logic [63:0] lane_r [4];
  logic [63:0] pend_r [3];
  logic [1:0]  pcnt_r;
  logic [63:0] len_r;
  logic        inmsg_r;
  logic [63:0] w_r, h_r, t_r;
  logic [3:0]  part_r;
  logic [1:0]  idx_r, pi_r;
  logic        last_r;
  logic        out_valid_r;
  logic [63:0] digest_r;

  logic        m_start;
  logic [63:0] m_a, m_b, m_p;
  logic        m_done;

  xxh_mul64 u_mul (
    .clk(clk), .rst_n(rst_n), .start(m_start), .a(m_a), .b(m_b),
    .done(m_done), .p(m_p)
  );

  logic        acc_in;
  logic [3:0]  n_eff;
  logic [63:0] w_mask;

  assign acc_in    = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_digest = digest_r;

  always_comb begin
    n_eff = (!in_last || in_byte_count > 4'd8) ? 4'd8 : in_byte_count;
    w_mask = (n_eff == 4'd8) ? 64'hFFFFFFFFFFFFFFFF
           : ((64'd1 << {n_eff[2:0], 3'b000}) - 64'd1);
  end

  // Multiplier is started in the cycle the state machine enters a state that
  // waits on it; operand a comes from t_r, operand b is the prime for the state.
  always_comb begin
    m_a = t_r;
    m_b = xxh_pkg::PR1;
    unique case (state_r)
      S_LR_A, S_MG_A, S_PW_A: m_b = xxh_pkg::PR2;
      S_G4_A, S_B1_A:         m_b = (state_r == S_B1_A) ? xxh_pkg::PR5 : xxh_pkg::PR1;
      S_AV_A, S_G4_B:         m_b = xxh_pkg::PR2;
      S_AV_C:                 m_b = xxh_pkg::PR3;
      default:                m_b = xxh_pkg::PR1;
    endcase
  end

  logic go_r;
  assign m_start = go_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      seed_r      <= xxh_pkg::SEED_RESET;
      pcnt_r      <= 2'd0;
      len_r       <= 64'd0;
      inmsg_r     <= 1'b0;
      out_valid_r <= 1'b0;
      go_r        <= 1'b0;
      lane_r[0]   <= xxh_pkg::PR1 + xxh_pkg::PR2;
      lane_r[1]   <= xxh_pkg::PR2;
      lane_r[2]   <= 64'd0;
      lane_r[3]   <= 64'd0 - xxh_pkg::PR1;
    end else begin
      go_r <= 1'b0;
      if (cfg_valid && cfg_ready) seed_r <= cfg_seed;
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (acc_in) begin
            logic [63:0] w;
            w = in_data_word & w_mask;
            w_r    <= w;
            last_r <= in_last;
            len_r  <= len_r + {60'd0, n_eff};
            part_r <= (n_eff == 4'd8) ? 4'd0 : n_eff;
            if (!inmsg_r) begin
              inmsg_r   <= 1'b1;
              lane_r[0] <= seed_r + xxh_pkg::PR1 + xxh_pkg::PR2;
              lane_r[1] <= seed_r + xxh_pkg::PR2;
              lane_r[2] <= seed_r;
              lane_r[3] <= seed_r - xxh_pkg::PR1;
            end
            if (n_eff == 4'd8 && pcnt_r == 2'd3) begin
              idx_r   <= 2'd0;
              t_r     <= pend_r[0];
              go_r    <= 1'b1;
              pcnt_r  <= 2'd0;
              state_r <= S_LR_A;
            end else begin
              if (n_eff == 4'd8) begin
                pend_r[pcnt_r] <= w;
                pcnt_r         <= pcnt_r + 2'd1;
              end
              state_r <= in_last ? S_MG_SUM : S_IDLE;
            end
          end
        end
        // Lane round: acc += v*PR2; rotl 31; *PR1.
        S_LR_A: if (m_done) begin
          t_r <= xxh_pkg::rotl(lane_r[idx_r] + m_p, 6'd31);
          go_r <= 1'b1; state_r <= S_LR_B;
        end
        S_LR_B: if (m_done) begin
          lane_r[idx_r] <= m_p;
          if (idx_r == 2'd3) state_r <= last_r ? S_MG_SUM : S_IDLE;
          else begin
            idx_r <= idx_r + 2'd1;
            t_r   <= (idx_r == 2'd2) ? w_r : pend_r[idx_r + 2'd1];
            go_r  <= 1'b1; state_r <= S_LR_A;
          end
        end
        S_MG_SUM: begin
          if (len_r >= 64'd32) begin
            h_r <= xxh_pkg::rotl(lane_r[0], 6'd1) + xxh_pkg::rotl(lane_r[1], 6'd7)
                 + xxh_pkg::rotl(lane_r[2], 6'd12) + xxh_pkg::rotl(lane_r[3], 6'd18);
            idx_r <= 2'd0; t_r <= lane_r[0]; go_r <= 1'b1; state_r <= S_MG_A;
          end else begin
            h_r <= seed_r + xxh_pkg::PR5; state_r <= S_LEN;
          end
        end
        // Merge: h ^= round(0,v); h = h*PR1 + PR4.
        S_MG_A: if (m_done) begin
          t_r <= xxh_pkg::rotl(m_p, 6'd31); go_r <= 1'b1; state_r <= S_MG_B;
        end
        S_MG_B: if (m_done) begin
          t_r <= h_r ^ m_p; go_r <= 1'b1; state_r <= S_MG_C;
        end
        S_MG_C: if (m_done) begin
          h_r <= m_p + xxh_pkg::PR4;
          if (idx_r == 2'd3) state_r <= S_LEN;
          else begin
            idx_r <= idx_r + 2'd1; t_r <= lane_r[idx_r + 2'd1];
            go_r <= 1'b1; state_r <= S_MG_A;
          end
        end
        S_LEN: begin
          h_r <= h_r + len_r; pi_r <= 2'd0; state_r <= S_PW_E;
        end
        S_PW_E: begin
          if (pi_r < pcnt_r) begin
            t_r <= pend_r[pi_r]; go_r <= 1'b1; state_r <= S_PW_A;
          end else if (part_r >= 4'd4) begin
            t_r <= {32'd0, w_r[31:0]}; go_r <= 1'b1; state_r <= S_G4_A;
          end else if (part_r != 4'd0) begin
            t_r <= {56'd0, w_r[7:0]}; go_r <= 1'b1; state_r <= S_B1_A;
          end else begin
            t_r <= h_r ^ (h_r >> 33); go_r <= 1'b1; state_r <= S_AV_A;
          end
        end
        S_PW_A: if (m_done) begin
          t_r <= xxh_pkg::rotl(m_p, 6'd31); go_r <= 1'b1; state_r <= S_PW_B;
        end
        S_PW_B: if (m_done) begin
          t_r <= xxh_pkg::rotl(h_r ^ m_p, 6'd27); go_r <= 1'b1; state_r <= S_PW_C;
        end
        S_PW_C: if (m_done) begin
          h_r <= m_p + xxh_pkg::PR4; pi_r <= pi_r + 2'd1; state_r <= S_PW_E;
        end
        S_G4_A: if (m_done) begin
          t_r <= xxh_pkg::rotl(h_r ^ m_p, 6'd23); go_r <= 1'b1; state_r <= S_G4_B;
        end
        S_G4_B: if (m_done) begin
          h_r <= m_p + xxh_pkg::PR3; w_r <= w_r >> 32;
          part_r <= part_r - 4'd4; state_r <= S_PW_E;
        end
        S_B1_A: if (m_done) begin
          t_r <= xxh_pkg::rotl(h_r ^ m_p, 6'd11); go_r <= 1'b1; state_r <= S_B1_B;
        end
        S_B1_B: if (m_done) begin
          h_r <= m_p; w_r <= w_r >> 8; part_r <= part_r - 4'd1; state_r <= S_PW_E;
        end
        S_AV_A: if (m_done) begin
          t_r <= m_p ^ (m_p >> 29); go_r <= 1'b1; state_r <= S_AV_C;
        end
        S_AV_C: if (m_done) begin
          h_r     <= m_p ^ (m_p >> 32);
          state_r <= S_OUT;
        end
        // The finished digest waits here while the previous one is still held.
        S_OUT: if (!out_valid_r) begin
          digest_r    <= h_r;
          out_valid_r <= 1'b1;
          inmsg_r     <= 1'b0;
          len_r       <= 64'd0;
          pcnt_r      <= 2'd0;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready) else $error("request taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(out_digest))
    else $error("result dropped");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> state_r == S_IDLE && !inmsg_r)
    else $error("digest without re-arm");
`endif

endmodule

// ===== rtl/xxh_mul64.sv =====
// Iterative 64x64 -> low 64 multiplier built from three 32x32 partial
// products, one per cycle. Depends on xxh_pkg.
module xxh_mul64 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] p
);

  logic [63:0] a_r, b_r, acc_r;
  logic [1:0]  step_r;
  logic        busy_r, done_r;
  logic [31:0] x, y;
  logic [63:0] pp;

  always_comb begin
    x = a_r[31:0];
    y = b_r[31:0];
    case (step_r)
      xxh_pkg::MUL_MID1: begin x = a_r[63:32]; y = b_r[31:0]; end
      xxh_pkg::MUL_MID2: begin x = a_r[31:0];  y = b_r[63:32]; end
      default: ;
    endcase
    pp = {32'd0, x} * {32'd0, y};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= xxh_pkg::MUL_LO;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        a_r    <= a;
        b_r    <= b;
        busy_r <= 1'b1;
        step_r <= xxh_pkg::MUL_LO;
      end else if (busy_r) begin
        case (step_r)
          xxh_pkg::MUL_LO: begin
            acc_r  <= pp;
            step_r <= xxh_pkg::MUL_MID1;
          end
          xxh_pkg::MUL_MID1: begin
            acc_r  <= acc_r + {pp[31:0], 32'd0};
            step_r <= xxh_pkg::MUL_MID2;
          end
          default: begin
            acc_r  <= acc_r + {pp[31:0], 32'd0};
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end
        endcase
      end
    end
  end

  assign done = done_r;
  assign p    = acc_r;

`ifndef ASSERT_OFF
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("multiplier done held");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(done_r) |-> $past(busy_r)) else $error("done without work");
  a_no_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("busy and done together");
`endif

endmodule

// ===== dv/tb_xxh64_stream_hash.sv =====
// Self-checking testbench for the XXH64 stream hash block.
// Depends on xxh_pkg (primes) and the xxh64_stream_hash RTL.

module tb_xxh64_stream_hash;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned MAX_CYCLES = 3_000_000;

  // Idling phases.
  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  class digest_scoreboard;
    logic [63:0] seed_reg;
    logic [63:0] lanes [4];
    logic [63:0] held [3];
    int unsigned held_cnt;
    logic [63:0] msg_len;
    bit active;
    logic [63:0] want_q[$];
    int unsigned err_cnt;
    int unsigned digests_seen;

    function new();
      seed_reg = xxh_pkg::SEED_RESET;
      held_cnt = 0;
      msg_len = 0;
      active = 0;
      err_cnt = 0;
      digests_seen = 0;
    endfunction

    function logic [63:0] rol(logic [63:0] x, int r);
      if (r == 0) return x;
      return (x << r) | (x >> (64 - r));
    endfunction

    function logic [63:0] round(logic [63:0] acc, logic [63:0] v);
      acc = acc + v * xxh_pkg::PR2;
      acc = rol(acc, 31);
      return acc * xxh_pkg::PR1;
    endfunction

    function void set_seed(logic [63:0] s);
      seed_reg = s;
    endfunction

    // Fold one accepted request into the model; queue a digest on the last word.
    function void note_request(logic [63:0] word, logic [3:0] cnt, bit is_last);
      logic [63:0] w, h;
      int n, part;
      w = word;
      n = cnt;
      if (!is_last || n > 8) n = 8;
      if (n < 8) w = w & ((64'd1 << (8 * n)) - 64'd1);
      if (!active) begin
        lanes[0] = seed_reg + xxh_pkg::PR1 + xxh_pkg::PR2;
        lanes[1] = seed_reg + xxh_pkg::PR2;
        lanes[2] = seed_reg;
        lanes[3] = seed_reg - xxh_pkg::PR1;
        active = 1;
      end
      msg_len = msg_len + 64'(n);
      part = n;
      if (n == 8) begin
        part = 0;
        if (held_cnt >= 3) begin
          for (int i = 0; i < 3; i++) lanes[i] = round(lanes[i], held[i]);
          lanes[3] = round(lanes[3], w);
          held_cnt = 0;
        end else begin
          held[held_cnt] = w;
          held_cnt++;
        end
      end
      if (!is_last) return;
      if (msg_len >= 32) begin
        h = rol(lanes[0], 1) + rol(lanes[1], 7) + rol(lanes[2], 12) + rol(lanes[3], 18);
        for (int i = 0; i < 4; i++) begin
          h = h ^ round(64'd0, lanes[i]);
          h = h * xxh_pkg::PR1 + xxh_pkg::PR4;
        end
      end else begin
        h = seed_reg + xxh_pkg::PR5;
      end
      h = h + msg_len;
      for (int i = 0; i < held_cnt; i++) begin
        h = h ^ round(64'd0, held[i]);
        h = rol(h, 27) * xxh_pkg::PR1 + xxh_pkg::PR4;
      end
      if (part >= 4) begin
        h = h ^ ({32'd0, w[31:0]} * xxh_pkg::PR1);
        h = rol(h, 23) * xxh_pkg::PR2 + xxh_pkg::PR3;
        w = w >> 32;
        part -= 4;
      end
      while (part > 0) begin
        h = h ^ ({56'd0, w[7:0]} * xxh_pkg::PR5);
        h = rol(h, 11) * xxh_pkg::PR1;
        w = w >> 8;
        part--;
      end
      h = h ^ (h >> 33);
      h = h * xxh_pkg::PR2;
      h = h ^ (h >> 29);
      h = h * xxh_pkg::PR3;
      h = h ^ (h >> 32);
      want_q.push_back(h);
      active = 0;
      msg_len = 0;
      held_cnt = 0;
    endfunction

    function void check_digest(logic [63:0] got);
      logic [63:0] exp_d;
      digests_seen++;
      if (want_q.size() == 0) begin
        $error("digest %h arrived with nothing expected", got);
        err_cnt++;
        return;
      end
      exp_d = want_q.pop_front();
      if (got !== exp_d) begin
        $error("digest mismatch: expected %h, actual %h", exp_d, got);
        err_cnt++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [63:0] cfg_seed;
  logic        in_valid;
  logic        in_ready;
  logic [63:0] in_data_word;
  logic [3:0]  in_byte_count;
  logic        in_last;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] out_digest;

  digest_scoreboard sb;
  idle_mode_t mode;
  longint unsigned cycle_cnt;
  int unsigned req_cnt;
  int unsigned seeds_used;

  xxh64_stream_hash dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_seed(cfg_seed),
    .in_valid(in_valid), .in_ready(in_ready), .in_data_word(in_data_word),
    .in_byte_count(in_byte_count), .in_last(in_last),
    .out_valid(out_valid), .out_ready(out_ready), .out_digest(out_digest)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_cnt = 0;
    forever begin
      @(posedge clk);
      cycle_cnt++;
      if (cycle_cnt > MAX_CYCLES) begin
        $display("tb_xxh64_stream_hash: done, errors");
        $finish;
      end
    end
  end

  function bit idle_roll(bit sender);
    case (mode)
      IDLE_SEND: return sender && ($urandom_range(99) < 80);
      IDLE_RECV: return !sender && ($urandom_range(99) < 80);
      IDLE_BOTH: return $urandom_range(99) < 8;
      default:   return 0;
    endcase
  endfunction

  // Receiver: stalls per the current phase and checks every accepted digest.
  initial begin
    out_ready = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) sb.check_digest(out_digest);
      out_ready <= !idle_roll(0);
    end
  end

  // Valid stays high after an accept so that words can follow back to back;
  // an idle cycle or drain() drops it.
  task automatic send_word(logic [63:0] word, logic [3:0] cnt, bit is_last);
    while (idle_roll(1)) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid      <= 1;
    in_data_word  <= word;
    in_byte_count <= cnt;
    in_last       <= is_last;
    do @(posedge clk); while (!in_ready);
    sb.note_request(word, cnt, is_last);
    req_cnt++;
  endtask

  // Sends a message of the given byte length; random content, junk above the count.
  task automatic send_message(int unsigned nbytes);
    int unsigned full;
    logic [3:0] tail;
    full = nbytes / 8;
    tail = 4'(nbytes % 8);
    for (int i = 0; i < full; i++) begin
      if (i == full - 1 && tail == 0 && $urandom_range(1))
        send_word({$urandom, $urandom}, 4'd8, 1);
      else
        send_word({$urandom, $urandom}, ($urandom_range(3) == 0) ? 4'($urandom) : 4'd8, 0);
      if (i == full - 1 && tail == 0 && sb.active == 0) return;
    end
    send_word({$urandom, $urandom}, tail, 1);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.want_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_seed(logic [63:0] s);
    cfg_valid <= 1;
    cfg_seed  <= s;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    sb.set_seed(s);
    seeds_used++;
  endtask

  initial begin
    logic [63:0] seeds [4];
    sb = new();
    mode = IDLE_NONE;
    req_cnt = 0;
    seeds_used = 0;
    rst_n = 0;
    cfg_valid = 0;
    cfg_seed = 0;
    in_valid = 0;
    in_data_word = 0;
    in_byte_count = 0;
    in_last = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: reset seed, empty message, field extremes, counts above eight.
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1);
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1);
    send_word(64'h0, 4'd8, 1);
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1);
    send_word(64'hA5A5_5A5A_0F0F_F0F0, 4'd9, 1);
    for (int c = 1; c < 8; c++) send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'(c), 1);
    // Non-last words with counts other than eight still count as eight bytes; a full stripe.
    send_word(64'h0123_4567_89AB_CDEF, 4'd0, 0);
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 0);
    send_word(64'h0, 4'd3, 0);
    send_word(64'h8000_0000_0000_0001, 4'd8, 0);
    send_word(64'hDEAD_BEEF_CAFE_F00D, 4'd5, 1);
    drain();

    seeds[0] = 64'hFFFF_FFFF_FFFF_FFFF;
    seeds[1] = 64'h0;
    seeds[2] = {$urandom, $urandom};
    seeds[3] = {$urandom, $urandom};
    for (int ph = 0; ph < 4; ph++) begin
      write_seed(seeds[ph]);
      mode = idle_mode_t'(ph);
      while (req_cnt < 235 * (ph + 1)) begin
        case ($urandom_range(9))
          0:       send_message($urandom_range(200, 40));
          1, 2:    send_message($urandom_range(31));
          default: send_message($urandom_range(80));
        endcase
        // Let the pipeline empty mid-phase, after messages ending with req_cnt in 301..319, with the sender held off.
        if (ph == 1 && req_cnt > 300 && req_cnt < 320) drain();
      end
      drain();
    end

    $display("Covered %0d requests and %0d digests over %0d seeds and four idling phases.",
             req_cnt, sb.digests_seen, seeds_used + 1);
    if (sb.err_cnt == 0 && sb.want_q.size() == 0)
      $display("tb_xxh64_stream_hash: done, clean");
    else
      $display("tb_xxh64_stream_hash: done, errors");
    $finish;
  end
endmodule

// ===== xxh64_stream_hash.f =====
rtl/xxh_pkg.sv
rtl/xxh_mul64.sv
rtl/xxh64_stream_hash.sv
dv/tb_xxh64_stream_hash.sv
